FILE: rtl/core/wfm_pkg.sv
// Package for the windowed FIFO mean block: payload structs, codes, control structs.
`default_nettype none
package wfm_pkg;

    localparam int ID_W     = 16;
    localparam int HEIGHT_W = 9;
    localparam int MEAN_W   = 9;
    localparam int STATUS_W = 2;

    localparam logic CMD_INSERT = 1'b0;
    localparam logic CMD_REMOVE = 1'b1;

    localparam logic [STATUS_W-1:0] ST_MEAN   = 2'd0;
    localparam logic [STATUS_W-1:0] ST_POPPED = 2'd1;
    localparam logic [STATUS_W-1:0] ST_EMPTY  = 2'd2;

    typedef struct packed {
        logic                cmd;
        logic [ID_W-1:0]     entry_id;
        logic [HEIGHT_W-1:0] height;
    } in_item_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [MEAN_W-1:0]   mean_height;
        logic [ID_W-1:0]     removed_id;
        logic [HEIGHT_W-1:0] removed_height;
    } out_item_t;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic load;      // take the accepted item, update the store
        logic div_step;  // one restoring divider iteration
        logic finish;    // load the result register
    } ctrl_cmd_t;

    // Status from the datapath to the controller
    typedef struct packed {
        logic div_last;  // current divider step is the final one
    } dp_stat_t;

endpackage
`default_nettype wire

FILE: rtl/core/windowed_fifo_mean.sv
// Top level of the windowed FIFO mean block: controller plus datapath.
//
// A bounded FIFO of up to CAPACITY entries (id, height) with a running sum.
// Item channel (item_valid/item_ready/item): cmd insert appends an entry,
// dropping the oldest one when full; cmd remove pops the oldest entry.
// Result channel (result_valid/result_ready/result): one transfer per item.
//   insert -> status mean, mean height rounded to nearest, ties to even
//   remove -> status removed with the popped id and height, or status empty
// item_ready is high only while the controller is idle. An insert runs the
// restoring divider between accept and finish, producing the SUM_W-bit
// quotient one bit per cycle, while a remove goes from accept straight to
// finish. The divider loop sets the insert rate.
// The result sits in an output register; the next item is taken while it
// waits. When the receiver stalls, the finished result of that next item is
// held inside until the output register frees up, and then no further item
// is taken.
// Reset (rst_n, asynchronous, active low) empties the store and drops any
// pending result; stored entries are never read before they are written.
`default_nettype none
module windowed_fifo_mean #(
    parameter int CAPACITY = 5
) (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire wfm_pkg::in_item_t item,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output wfm_pkg::out_item_t     result
);

    wfm_pkg::ctrl_cmd_t ctrl;
    wfm_pkg::dp_stat_t  stat;

    // sequence accept, divide and finish
    wfm_ctrl u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_ready   (item_ready),
        .item_cmd     (item.cmd),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .ctrl         (ctrl),
        .stat         (stat)
    );

    // hold the ring store, sum, divider and output register
    wfm_datapath #(
        .CAPACITY (CAPACITY)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .ctrl   (ctrl),
        .stat   (stat),
        .result (result)
    );

endmodule
`default_nettype wire

FILE: rtl/core/wfm_ctrl.sv
// Controller state machine for the windowed FIFO mean block.
`default_nettype none
module wfm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output logic                   item_ready,
    input  wire logic              item_cmd,
    output logic                   result_valid,
    input  wire logic              result_ready,
    output wfm_pkg::ctrl_cmd_t     ctrl,
    input  wire wfm_pkg::dp_stat_t stat
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_DIV  = 2'd1;
    localparam logic [1:0] S_FIN  = 2'd2;

    logic [1:0] state_reg, state_next;
    logic       valid_reg, valid_next;
    logic       accept;
    logic       slot_free;

    assign item_ready   = (state_reg == S_IDLE);
    assign accept       = item_valid && item_ready;
    assign result_valid = valid_reg;
    assign slot_free    = !valid_reg || result_ready;

    always_comb
    begin
        state_next    = state_reg;
        valid_next    = valid_reg;
        ctrl.load     = 1'b0;
        ctrl.div_step = 1'b0;
        ctrl.finish   = 1'b0;
        if (valid_reg && result_ready)
        begin
            valid_next = 1'b0;
        end
        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    ctrl.load  = 1'b1;
                    state_next = (item_cmd == wfm_pkg::CMD_INSERT) ? S_DIV : S_FIN;
                end
            end
            S_DIV:
            begin
                ctrl.div_step = 1'b1;
                if (stat.div_last)
                begin
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold until the output register is free
                if (slot_free)
                begin
                    ctrl.finish = 1'b1;
                    valid_next  = 1'b1;
                    state_next  = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/wfm_datapath.sv
// Datapath: ring store, running sum, restoring divider and result register.
`default_nettype none
module wfm_datapath #(
    parameter int CAPACITY = 5
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire wfm_pkg::in_item_t  item,
    input  wire wfm_pkg::ctrl_cmd_t ctrl,
    output wfm_pkg::dp_stat_t       stat,
    output wfm_pkg::out_item_t      result
);

    localparam int IDX_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int SUM_W = $clog2(CAPACITY * 511 + 1);
    localparam int STEP_W = (SUM_W > 1) ? $clog2(SUM_W) : 1;
    localparam logic [CNT_W-1:0]  CAP_C     = CNT_W'(CAPACITY);
    localparam logic [CNT_W:0]    CAP_X     = (CNT_W + 1)'(CAPACITY);
    localparam logic [IDX_W-1:0]  LAST_IDX  = IDX_W'(CAPACITY - 1);
    localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(SUM_W - 1);

    logic [wfm_pkg::ID_W-1:0]     id_mem_reg [CAPACITY];
    logic [wfm_pkg::HEIGHT_W-1:0] ht_mem_reg [CAPACITY];

    logic [IDX_W-1:0]  head_reg, head_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic [SUM_W-1:0]  sum_reg, sum_next;
    logic [SUM_W-1:0]  num_reg, num_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              op_insert_reg, op_insert_next;
    wfm_pkg::out_item_t pend_reg, pend_next;
    wfm_pkg::out_item_t result_reg, result_next;

    logic                         full;
    logic [IDX_W-1:0]             head_inc;
    logic [CNT_W:0]               tail_sum;
    logic [IDX_W-1:0]             tail_slot;
    logic [IDX_W-1:0]             wr_slot;
    logic                         wr_en;
    logic [wfm_pkg::ID_W-1:0]     head_id;
    logic [wfm_pkg::HEIGHT_W-1:0] head_ht;
    logic [CNT_W:0]               rem_shift;
    logic                         rem_ge;
    logic [CNT_W:0]               twice_rem;
    logic                         round_up;
    logic [wfm_pkg::MEAN_W-1:0]   mean;

    assign full     = (count_reg == CAP_C);
    assign head_inc = (head_reg == LAST_IDX) ? '0 : head_reg + 1'b1;
    assign tail_sum = {{(CNT_W + 1 - IDX_W){1'b0}}, head_reg} + {1'b0, count_reg};
    assign tail_slot = (tail_sum >= CAP_X) ? IDX_W'(tail_sum - CAP_X) : IDX_W'(tail_sum);
    assign wr_slot  = full ? head_reg : tail_slot;
    assign wr_en    = ctrl.load && (item.cmd == wfm_pkg::CMD_INSERT);
    assign head_id  = id_mem_reg[head_reg];
    assign head_ht  = ht_mem_reg[head_reg];

    // restoring divider step: sum / count, quotient shifts into num_reg
    assign rem_shift = {rem_reg, num_reg[SUM_W-1]};
    assign rem_ge    = (rem_shift >= {1'b0, count_reg});

    // round to nearest, ties to even
    assign twice_rem = {rem_reg, 1'b0};
    assign round_up  = (twice_rem > {1'b0, count_reg})
                    || ((twice_rem == {1'b0, count_reg}) && num_reg[0]);
    assign mean      = wfm_pkg::MEAN_W'(num_reg) + wfm_pkg::MEAN_W'(round_up);

    assign stat.div_last = (step_reg == STEP_LAST);
    assign result        = result_reg;

    always_comb
    begin
        head_next      = head_reg;
        count_next     = count_reg;
        sum_next       = sum_reg;
        num_next       = num_reg;
        rem_next       = rem_reg;
        step_next      = step_reg;
        op_insert_next = op_insert_reg;
        pend_next      = pend_reg;
        result_next    = result_reg;

        if (ctrl.load)
        begin
            op_insert_next = (item.cmd == wfm_pkg::CMD_INSERT);
            pend_next      = '0;
            if (item.cmd == wfm_pkg::CMD_INSERT)
            begin
                // drop the oldest entry when full, then append
                if (full)
                begin
                    head_next = head_inc;
                    sum_next  = sum_reg - SUM_W'(head_ht) + SUM_W'(item.height);
                end
                else
                begin
                    count_next = count_reg + 1'b1;
                    sum_next   = sum_reg + SUM_W'(item.height);
                end
                num_next  = sum_next;
                rem_next  = '0;
                step_next = '0;
            end
            else if (count_reg == '0)
            begin
                pend_next.status = wfm_pkg::ST_EMPTY;
            end
            else
            begin
                pend_next.status         = wfm_pkg::ST_POPPED;
                pend_next.removed_id     = head_id;
                pend_next.removed_height = head_ht;
                head_next  = head_inc;
                count_next = count_reg - 1'b1;
                sum_next   = sum_reg - SUM_W'(head_ht);
            end
        end

        if (ctrl.div_step)
        begin
            rem_next  = rem_ge ? CNT_W'(rem_shift - {1'b0, count_reg}) : CNT_W'(rem_shift);
            num_next  = {num_reg[SUM_W-2:0], rem_ge};
            step_next = step_reg + 1'b1;
        end

        if (ctrl.finish)
        begin
            if (op_insert_reg)
            begin
                result_next             = '0;
                result_next.status      = wfm_pkg::ST_MEAN;
                result_next.mean_height = mean;
            end
            else
            begin
                result_next = pend_reg;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            count_reg <= '0;
            sum_reg   <= '0;
            step_reg  <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            count_reg <= count_next;
            sum_reg   <= sum_next;
            step_reg  <= step_next;
        end
    end

    always_ff @(posedge clk)
    begin
        num_reg       <= num_next;
        rem_reg       <= rem_next;
        op_insert_reg <= op_insert_next;
        pend_reg      <= pend_next;
        result_reg    <= result_next;
        if (wr_en)
        begin
            id_mem_reg[wr_slot] <= item.entry_id;
            ht_mem_reg[wr_slot] <= item.height;
        end
    end

endmodule
`default_nettype wire

FILE: rtl/core/wfm_checker.sv
// Port-level checker for the windowed FIFO mean block, bound to the top level.
`default_nettype none
module wfm_checker (
    input wire logic               clk,
    input wire logic               rst_n,
    input wire logic               item_valid,
    input wire logic               item_ready,
    input wire logic               result_valid,
    input wire logic               result_ready,
    input wire wfm_pkg::out_item_t result
);

    // hold a stalled result unchanged
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("stalled result changed or dropped");

    // one item at a time: busy right after a transfer
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken on consecutive cycles");

    a_mean_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == wfm_pkg::ST_MEAN
        |-> result.removed_id == '0 && result.removed_height == '0)
        else $error("insert result carries removed fields");

    a_remove_fields: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && (result.status == wfm_pkg::ST_POPPED
                         || result.status == wfm_pkg::ST_EMPTY)
        |-> result.mean_height == '0)
        else $error("remove result carries a mean");

endmodule

bind windowed_fifo_mean wfm_checker u_wfm_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .result       (result)
);
`default_nettype wire

FILE: test/tb_top.sv
// Self-checking testbench for windowed_fifo_mean: bounded FIFO with a rounded running mean.
`timescale 1ns / 100ps
module tb_top;

    localparam int CAPACITY     = 5;
    localparam int HALF_PERIOD  = 6;
    localparam int QUIET_LIMIT  = 2000;  // cycles with no transfer on either channel
    localparam int DRAIN_CYCLES = 40;    // > one insert plus slack
    localparam int HOLD_CYCLES  = 300;

    logic               clk;
    logic               rst_n;
    logic               item_valid;
    logic               item_ready;
    wfm_pkg::in_item_t  item;
    logic               result_valid;
    logic               result_ready;
    wfm_pkg::out_item_t result;

    windowed_fifo_mean #(
        .CAPACITY(CAPACITY)
    ) u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_ready  (item_ready),
        .item        (item),
        .result_valid(result_valid),
        .result_ready(result_ready),
        .result      (result)
    );

    initial
    begin
        clk = 1'b0;
        forever #HALF_PERIOD clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Shadow of the block's store: ring of ids and heights, oldest slot,
    // fill level and running height sum.
    // ------------------------------------------------------------------
    logic [wfm_pkg::ID_W-1:0]     store_ids     [CAPACITY];
    logic [wfm_pkg::HEIGHT_W-1:0] store_heights [CAPACITY];
    int                           store_head;
    int                           store_count;
    int                           store_sum;

    // Results still owed by the block, oldest first.
    wfm_pkg::out_item_t pending_results [$];

    int fail_count;
    int report_count;
    int quiet_cycles;

    // Sender burst control.
    bit sender_gaps_on;
    int burst_left;

    // Receiver control: chance (percent) of starting a stall run, and a
    // requested long hold-off that the receiver process counts down itself.
    int stall_pct;
    int hold_request;

    // Take the oldest entry out of the shadow store.
    function automatic void pop_oldest_entry(
        output logic [wfm_pkg::ID_W-1:0]     popped_id,
        output logic [wfm_pkg::HEIGHT_W-1:0] popped_height);
        popped_id     = store_ids[store_head];
        popped_height = store_heights[store_head];
        store_sum    -= popped_height;
        store_head    = (store_head + 1) % CAPACITY;
        store_count  -= 1;
    endfunction

    // Advance the shadow store by one command and return the result it owes.
    function automatic wfm_pkg::out_item_t apply_command(input wfm_pkg::in_item_t cmd_item);
        wfm_pkg::out_item_t           res;
        logic [wfm_pkg::ID_W-1:0]     popped_id;
        logic [wfm_pkg::HEIGHT_W-1:0] popped_height;
        int                           slot;
        int                           quotient;
        int                           remainder;
        res = '0;
        if (cmd_item.cmd == wfm_pkg::CMD_INSERT)
        begin
            // Full store: evict the oldest entry before appending.
            if (store_count >= CAPACITY)
                pop_oldest_entry(popped_id, popped_height);
            slot                = (store_head + store_count) % CAPACITY;
            store_ids[slot]     = cmd_item.entry_id;
            store_heights[slot] = cmd_item.height;
            store_count        += 1;
            store_sum          += cmd_item.height;
            // Round to nearest; on an exact half, round up only an odd quotient.
            quotient  = store_sum / store_count;
            remainder = store_sum % store_count;
            if (2 * remainder > store_count ||
                (2 * remainder == store_count && (quotient % 2) == 1))
                quotient += 1;
            res.status      = wfm_pkg::ST_MEAN;
            res.mean_height = wfm_pkg::MEAN_W'(quotient);
        end
        else if (store_count == 0)
        begin
            res.status = wfm_pkg::ST_EMPTY;
        end
        else
        begin
            pop_oldest_entry(popped_id, popped_height);
            res.status         = wfm_pkg::ST_POPPED;
            res.removed_id     = popped_id;
            res.removed_height = popped_height;
        end
        return res;
    endfunction

    function automatic wfm_pkg::in_item_t make_item(
        input logic                         cmd_bit,
        input logic [wfm_pkg::ID_W-1:0]     id_val,
        input logic [wfm_pkg::HEIGHT_W-1:0] height_val);
        wfm_pkg::in_item_t it;
        it.cmd      = cmd_bit;
        it.entry_id = id_val;
        it.height   = height_val;
        return it;
    endfunction

    // Random command; heights lean toward the extremes now and then.
    function automatic wfm_pkg::in_item_t random_item(input int insert_pct);
        wfm_pkg::in_item_t it;
        int                pick;
        it.cmd      = ($urandom_range(0, 99) < insert_pct) ? wfm_pkg::CMD_INSERT
                                                           : wfm_pkg::CMD_REMOVE;
        it.entry_id = wfm_pkg::ID_W'($urandom);
        pick        = $urandom_range(0, 9);
        if (pick == 0)
            it.height = '0;
        else if (pick == 1)
            it.height = '1;
        else
            it.height = wfm_pkg::HEIGHT_W'($urandom_range(0,
                                           (1 << wfm_pkg::HEIGHT_W) - 1));
        return it;
    endfunction

    // Offer one item, hold it until the transfer, then maybe open a gap.
    task automatic send_item(input wfm_pkg::in_item_t next_item);
        int gap;
        @(negedge clk);
        item_valid <= 1'b1;
        item       <= next_item;
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        pending_results.push_back(apply_command(next_item));
        if (burst_left > 0)
            burst_left -= 1;
        if (sender_gaps_on && burst_left == 0)
        begin
            burst_left = $urandom_range(1, 16);
            gap        = $urandom_range(1, 6);
            @(negedge clk);
            item_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic send_random(input int n_items, input int insert_pct);
        repeat (n_items) send_item(random_item(insert_pct));
    endtask

    // ------------------------------------------------------------------
    // Test tasks
    // ------------------------------------------------------------------

    // Remove from the empty store, with junk in the ignored fields.
    task automatic test_empty_remove();
        send_item(make_item(wfm_pkg::CMD_REMOVE, 16'hFFFF, 9'h1FF));
        send_item(make_item(wfm_pkg::CMD_REMOVE, 16'h0000, 9'h000));
    endtask

    // Grow the store from one to five entries; exercise both tie cases.
    task automatic test_mean_rounding();
        send_item(make_item(wfm_pkg::CMD_INSERT, 16'h0000, 9'd0));
        send_item(make_item(wfm_pkg::CMD_INSERT, 16'hFFFF, 9'd1));   // 1/2: tie, even stays
        send_item(make_item(wfm_pkg::CMD_INSERT, 16'h1234, 9'd2));
        send_item(make_item(wfm_pkg::CMD_INSERT, 16'h8001, 9'd3));   // 6/4: tie, odd rounds up
        send_item(make_item(wfm_pkg::CMD_INSERT, 16'h7FFE, 9'd511));
    endtask

    // Evict from a full store, drain it, then saturate the running sum.
    task automatic test_full_eviction();
        send_item(make_item(wfm_pkg::CMD_INSERT, 16'hA5A5, 9'd511));
        repeat (CAPACITY) send_item(make_item(wfm_pkg::CMD_REMOVE, 16'h5A5A, 9'h0AA));
        send_item(make_item(wfm_pkg::CMD_REMOVE, 16'h0001, 9'h155));
        for (int i = 0; i <= CAPACITY; i++)
            send_item(make_item(wfm_pkg::CMD_INSERT, 16'(16'hFF00 + i), 9'd511));
        repeat (2) send_item(make_item(wfm_pkg::CMD_REMOVE, 16'hFFFF, 9'h1FF));
    endtask

    // Mixed traffic; the insert bias moves the fill level around so that
    // empty removes, partial fills and evictions all show up.
    task automatic test_random_traffic();
        sender_gaps_on = 1'b1;
        stall_pct = 0;
        send_random(100, 80);
        stall_pct = 20;
        send_random(100, 50);
        stall_pct = 50;
        send_random(100, 30);
        stall_pct = 10;
        send_random(100, 60);
    endtask

    // Hold off the receiver for a long stretch while items keep coming,
    // so the block fills up and drops item_ready.
    task automatic test_receiver_hold_off();
        sender_gaps_on = 1'b0;
        stall_pct      = 0;
        hold_request   = HOLD_CYCLES;
        send_random(30, 60);
        sender_gaps_on = 1'b1;
    endtask

    // Back-to-back items with an always-ready receiver.
    task automatic test_full_rate();
        sender_gaps_on = 1'b0;
        stall_pct      = 0;
        send_random(150, 55);
        sender_gaps_on = 1'b1;
        stall_pct      = 15;
    endtask

    // ------------------------------------------------------------------
    // Receiver: ready most of the time, with stall runs of random length
    // and an occasional long hold-off counted here.
    // ------------------------------------------------------------------
    initial
    begin
        int hold_left;
        int stall_left;
        hold_left    = 0;
        stall_left   = 0;
        result_ready = 1'b0;
        forever
        begin
            @(negedge clk);
            if (hold_request > 0)
            begin
                hold_left    = hold_request;
                hold_request = 0;
            end
            if (hold_left > 0)
            begin
                hold_left   -= 1;
                result_ready <= 1'b0;
            end
            else if (stall_left > 0)
            begin
                stall_left  -= 1;
                result_ready <= 1'b0;
            end
            else
            begin
                result_ready <= 1'b1;
                if ($urandom_range(0, 99) < stall_pct)
                    stall_left = $urandom_range(1, 8);
            end
        end
    end

    // ------------------------------------------------------------------
    // Result checker: compare each result transfer with the oldest
    // expectation, field by field.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        wfm_pkg::out_item_t expected_result;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_results.size() == 0)
            begin
                fail_count += 1;
                if (report_count < 10)
                begin
                    report_count += 1;
                    $display("unexpected result: status %0d mean %0d id %h height %0d",
                             result.status, result.mean_height,
                             result.removed_id, result.removed_height);
                end
            end
            else
            begin
                expected_result = pending_results.pop_front();
                if (result.status !== expected_result.status ||
                    result.mean_height !== expected_result.mean_height ||
                    result.removed_id !== expected_result.removed_id ||
                    result.removed_height !== expected_result.removed_height)
                begin
                    fail_count += 1;
                    if (report_count < 10)
                    begin
                        report_count += 1;
                        $display("mismatch: expected status %0d mean %0d id %h height %0d",
                                 expected_result.status, expected_result.mean_height,
                                 expected_result.removed_id, expected_result.removed_height);
                        $display("          got      status %0d mean %0d id %h height %0d",
                                 result.status, result.mean_height,
                                 result.removed_id, result.removed_height);
                    end
                end
            end
        end
    end

    // Watchdog: count cycles with no transfer on either channel.
    always @(posedge clk)
    begin
        if ((item_valid && item_ready) || (result_valid && result_ready))
            quiet_cycles = 0;
        else
        begin
            quiet_cycles += 1;
            if (quiet_cycles >= QUIET_LIMIT)
            begin
                $display("Simulation FAILED");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        rst_n          = 1'b0;
        item_valid     = 1'b0;
        item           = '0;
        fail_count     = 0;
        report_count   = 0;
        quiet_cycles   = 0;
        sender_gaps_on = 1'b0;
        burst_left     = 0;
        stall_pct      = 0;
        hold_request   = 0;
        store_head     = 0;
        store_count    = 0;
        store_sum      = 0;

        // Hold reset, then release it on a falling edge, away from the rising edge.
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        test_empty_remove();
        test_mean_rounding();
        test_full_eviction();
        test_random_traffic();
        test_receiver_hold_off();
        test_full_rate();

        // Drop valid, wait for every owed result, then let the block settle.
        @(negedge clk);
        item_valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
